FILE: sv/lfcf_pkg.sv
// ----------------------------------------------------------------------------
// lfcf_pkg
// Shared types and constants of the lowpass feedback comb filter.
// ----------------------------------------------------------------------------
package lfcf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 16;
  localparam int LEN_W      = 11;
  localparam int CFG_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 44;
  localparam int FIFO_DEPTH = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COEF_W-1:0]          coef_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;

  localparam sample_t SAMPLE_MAX = 24'sh7F_FFFF;
  localparam sample_t SAMPLE_MIN = 24'sh80_0000;

  localparam len_t  DELAY_RESET    = 11'd1024;
  localparam coef_t DAMPING_RESET  = 16'd13107;
  localparam coef_t FEEDBACK_RESET = 16'd55705;

  typedef enum logic [1:0] {
    REG_DELAY_LENGTH = 2'd0,
    REG_DAMPING      = 2'd1,
    REG_FEEDBACK     = 2'd2,
    REG_MUTED        = 2'd3
  } reg_index_t;

  // per-item control carried from the address stage into the MAC
  typedef struct packed {
    logic muted;
    logic len_one;
    logic xl_zero;
    logic xl1_zero;
    logic yl_zero;
    logic yl_bypass;
  } lfcf_ctl_t;

endpackage

FILE: sv/lfcf_hist_ram.sv
// ----------------------------------------------------------------------------
// lfcf_hist_ram
// Input and output history stores: synchronous RAMs with registered reads.
// Input history has one write and two read ports, output history one each.
// ----------------------------------------------------------------------------
module lfcf_hist_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              x_we,
  input  logic [AW-1:0]     x_waddr,
  input  lfcf_pkg::sample_t x_wdata,
  input  logic              x_rd_en,
  input  logic [AW-1:0]     x_raddr_a,
  input  logic [AW-1:0]     x_raddr_b,
  output lfcf_pkg::sample_t x_rdata_a,
  output lfcf_pkg::sample_t x_rdata_b,
  input  logic              y_we,
  input  logic [AW-1:0]     y_waddr,
  input  lfcf_pkg::sample_t y_wdata,
  input  logic [AW-1:0]     y_raddr,
  output lfcf_pkg::sample_t y_rdata
);
  import lfcf_pkg::*;

  sample_t x_mem [DEPTH];
  sample_t y_mem [DEPTH];

  // input history
  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    if (x_rd_en) begin
      x_rdata_a <= x_mem[x_raddr_a];
      x_rdata_b <= x_mem[x_raddr_b];
    end
  end

  // output history; same-edge write of the read entry is forwarded outside
  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[y_waddr] <= y_wdata;
    end
    if (x_rd_en) begin
      y_rdata <= y_mem[y_raddr];
    end
  end

endmodule

FILE: sv/lfcf_mac.sv
// ----------------------------------------------------------------------------
// lfcf_mac
// Two-stage arithmetic: feed-forward products, then the recursive
// multiply-add through the last output, rounding and saturation.
// ----------------------------------------------------------------------------
module lfcf_mac #(
  parameter int AW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  lfcf_pkg::lfcf_ctl_t  s1_ctl,
  input  logic [AW-1:0]        s1_waddr,
  input  lfcf_pkg::sample_t    xl,
  input  lfcf_pkg::sample_t    xl1,
  input  lfcf_pkg::sample_t    yl,
  input  lfcf_pkg::coef_t      damping,
  input  lfcf_pkg::coef_t      feedback,
  output logic                 y_we,
  output logic [AW-1:0]        y_waddr,
  output lfcf_pkg::sample_t    y_wdata,
  output logic                 res_valid,
  output lfcf_pkg::sample_t    res_data
);
  import lfcf_pkg::*;

  localparam int PROD_W = SAMPLE_W + COEF_W + 1;
  localparam int LOOP_W = SAMPLE_W + COEF_W + 2;
  localparam int RES_W  = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [RES_W-1:0] RES_MAX    = RES_W'(SAMPLE_MAX);
  localparam logic signed [RES_W-1:0] RES_MIN    = RES_W'(SAMPLE_MIN);

  sample_t                   xl_v;
  sample_t                   xl1_v;
  sample_t                   yl_v;
  logic signed [PROD_W-1:0]  m1;
  logic signed [PROD_W-1:0]  m2;
  logic signed [ACC_W-1:0]   p_next;
  logic [COEF_W:0]           c_next;

  logic                      s2_valid;
  logic                      s2_muted;
  logic [AW-1:0]             s2_waddr;
  logic signed [ACC_W-1:0]   s2_p;
  logic [COEF_W:0]           s2_c;
  sample_t                   last_output;

  logic signed [LOOP_W-1:0]  loop_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [RES_W-1:0]   rounded;
  sample_t                   y;

  // stage 1: select history taps, feed-forward products
  always_comb begin
    xl_v  = s1_ctl.xl_zero  ? '0 : xl;
    xl1_v = s1_ctl.xl1_zero ? '0 : xl1;
    priority if (s1_ctl.yl_zero) begin
      yl_v = '0;
    end else if (s1_ctl.yl_bypass) begin
      yl_v = last_output;
    end else begin
      yl_v = yl;
    end
    m1 = PROD_W'(xl1_v) * $signed({1'b0, damping});
    // with a delay of one, y[t-L] is the last output: fold R into the loop
    m2 = s1_ctl.len_one ? '0 : PROD_W'(yl_v) * $signed({1'b0, feedback});
    c_next = s1_ctl.len_one ? ({1'b0, damping} + {1'b0, feedback}) : {1'b0, damping};
    p_next = ACC_W'($signed({xl_v, {FRAC_W{1'b0}}})) - ACC_W'(m1) + ACC_W'(m2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_muted <= s1_ctl.muted;
    s2_waddr <= s1_waddr;
    s2_p     <= p_next;
    s2_c     <= c_next;
  end

  // stage 2: recursive term, round to nearest (ties up), saturate
  always_comb begin
    loop_prod = LOOP_W'(last_output) * $signed({1'b0, s2_c});
    acc       = s2_p + ACC_W'(loop_prod) + ROUND_BIAS;
    rounded   = acc[ACC_W-1:FRAC_W];
    priority if (rounded > RES_MAX) begin
      y = SAMPLE_MAX;
    end else if (rounded < RES_MIN) begin
      y = SAMPLE_MIN;
    end else begin
      y = rounded[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_output <= '0;
    end else if (s2_valid && !s2_muted) begin
      last_output <= y;
    end
  end

  // write-back and result
  assign y_we      = s2_valid && !s2_muted;
  assign y_waddr   = s2_waddr;
  assign y_wdata   = y;
  assign res_valid = s2_valid;
  assign res_data  = s2_muted ? '0 : y;

endmodule

FILE: sv/lfcf_out_fifo.sv
// ----------------------------------------------------------------------------
// lfcf_out_fifo
// Small result queue between the pipeline and the output channel.
// Space is reserved at input transfer, so a push always finds room.
// ----------------------------------------------------------------------------
module lfcf_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lfcf_pkg::sample_t push_data,
  output logic              valid,
  input  logic              ready,
  output lfcf_pkg::sample_t data
);
  import lfcf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  sample_t        entries [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;

  assign pop   = valid && ready;
  assign valid = (count != '0);
  assign data  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/lowpass_feedback_comb_filter_top.sv
// ----------------------------------------------------------------------------
// lowpass_feedback_comb_filter_top
// Damped reverb comb: y = x[t-L] - g*x[t-L-1] + g*y[t-1] + R*y[t-L].
// ----------------------------------------------------------------------------
// A sample enters every clock unless the four-entry result queue is full;
// results pass stages 1 and 2 into the queue, which lets inputs keep flowing
// while a result waits. The rate is set by the loop through the last-output
// register: one 24x18 multiply-add with rounding and saturation per cycle.
// Both histories sit in RAMs read at the input transfer; the output history
// entry written in the same cycle is forwarded from the last-output register.
// A fill count stands in for zeroed histories, so there is no clearing pass
// after reset. Delay lengths of 0 act as 1 and lengths above MAX_DELAY-2 act
// as MAX_DELAY-2. While muted, every sample returns zero and no state changes.
// Users must write registers only while the block is idle (not enforced).
module lowpass_feedback_comb_filter_top #(
  parameter int MAX_DELAY = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lfcf_pkg::sample_t      sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lfcf_pkg::sample_t      sample_out,
  input  logic                   cfg_write,
  input  lfcf_pkg::reg_index_t   cfg_index,
  input  lfcf_pkg::cfg_data_t    cfg_data
);
  import lfcf_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int KW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int OW = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  len_t  delay_length;
  coef_t damping;
  coef_t feedback;
  logic  muted;

  logic [AW-1:0] write_pointer;
  logic [AW-1:0] fill_count;
  logic [OW-1:0] occupancy;

  logic          fire;
  logic          pop;
  logic [KW-1:0] len_ext;
  logic [KW-1:0] len_clamped;
  logic [AW-1:0] back_l;
  logic [AW-1:0] back_l1;
  logic [AW-1:0] addr_l;
  logic [AW-1:0] addr_l1;
  lfcf_ctl_t     ctl_next;

  logic          s1_valid;
  lfcf_ctl_t     s1_ctl;
  logic [AW-1:0] s1_waddr;

  sample_t       xl;
  sample_t       xl1;
  sample_t       yl;
  logic          y_we;
  logic [AW-1:0] y_waddr;
  sample_t       y_wdata;
  logic          res_valid;
  sample_t       res_data;

  // address 'back' samples behind the write pointer, modulo the depth
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] back);
    logic [AW:0] diff;
    diff = {1'b0, wp} - {1'b0, back};
    if (diff[AW]) begin
      diff = diff + (AW+1)'(MAX_DELAY);
    end
    return diff[AW-1:0];
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= DELAY_RESET;
      damping      <= DAMPING_RESET;
      feedback     <= FEEDBACK_RESET;
      muted        <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY_LENGTH: delay_length <= cfg_data[LEN_W-1:0];
        REG_DAMPING:      damping      <= cfg_data[COEF_W-1:0];
        REG_FEEDBACK:     feedback     <= cfg_data[COEF_W-1:0];
        REG_MUTED:        muted        <= cfg_data[0];
      endcase
    end
  end

  // input handshake: room is reserved in the result queue per transfer
  assign fire     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (occupancy < OW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy + OW'(fire) - OW'(pop);
    end
  end

  // delay clamp and read addresses
  always_comb begin
    len_ext = KW'(delay_length);
    priority if (len_ext == '0) begin
      len_clamped = KW'(1);
    end else if (len_ext > KW'(MAX_DELAY - 2)) begin
      len_clamped = KW'(MAX_DELAY - 2);
    end else begin
      len_clamped = len_ext;
    end
    back_l  = len_clamped[AW-1:0];
    back_l1 = back_l + 1'b1;
    addr_l  = ring_back(write_pointer, back_l);
    addr_l1 = ring_back(write_pointer, back_l1);
  end

  // per-item control: unwritten taps read as zero, same-edge write forwarded
  always_comb begin
    ctl_next.muted     = muted;
    ctl_next.len_one   = (back_l == AW'(1));
    ctl_next.xl_zero   = (back_l > fill_count);
    ctl_next.xl1_zero  = (back_l1 > fill_count);
    ctl_next.yl_zero   = (back_l > fill_count);
    ctl_next.yl_bypass = y_we && (y_waddr == addr_l);
  end

  // write pointer advances on every unmuted transfer; fill count too, until MAX_DELAY-1
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
    end else if (fire && !muted) begin
      write_pointer <= (write_pointer == AW'(MAX_DELAY - 1)) ? '0
                                                             : write_pointer + 1'b1;
      if (fill_count != AW'(MAX_DELAY - 1)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // stage 1 control, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_ctl   <= ctl_next;
      s1_waddr <= write_pointer;
    end
  end

  lfcf_hist_ram #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_hist_ram (
    .clk       (clk),
    .x_we      (fire && !muted),
    .x_waddr   (write_pointer),
    .x_wdata   (sample_in),
    .x_rd_en   (fire),
    .x_raddr_a (addr_l),
    .x_raddr_b (addr_l1),
    .x_rdata_a (xl),
    .x_rdata_b (xl1),
    .y_we      (y_we),
    .y_waddr   (y_waddr),
    .y_wdata   (y_wdata),
    .y_raddr   (addr_l),
    .y_rdata   (yl)
  );

  lfcf_mac #(
    .AW (AW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_waddr  (s1_waddr),
    .xl        (xl),
    .xl1       (xl1),
    .yl        (yl),
    .damping   (damping),
    .feedback  (feedback),
    .y_we      (y_we),
    .y_waddr   (y_waddr),
    .y_wdata   (y_wdata),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  lfcf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .valid     (out_valid),
    .ready     (out_ready),
    .data      (sample_out)
  );

endmodule
